@@ rtl/kst_pkg.sv @@
// Shared types and constants for the key to sequential id table.
`timescale 1ns / 1ps

package kst_pkg;

    localparam int KEY_W   = 31;
    localparam int LABEL_W = 9;

    // Function codes of an input beat
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key;
    } t_kst_in;

    typedef struct packed {
        logic               found;
        logic [LABEL_W-1:0] label;
        logic [LABEL_W-1:0] entry_count;
        logic               table_full;
    } t_kst_out;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_kst_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic hit;
        logic exhausted;
    } t_kst_sts;

endpackage

@@ rtl/kst_in_if.sv @@
// Input channel interface: valid, ready and one request beat.
`timescale 1ns / 1ps

interface kst_in_if;
    logic             valid;
    logic             ready;
    kst_pkg::t_kst_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/kst_out_if.sv @@
// Output channel interface: valid, ready and one result beat.
`timescale 1ns / 1ps

interface kst_out_if;
    logic              valid;
    logic              ready;
    kst_pkg::t_kst_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/kst_ctrl.sv @@
// Controller state machine: accept, scan, present result.
`timescale 1ns / 1ps

module kst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  kst_pkg::t_kst_sts i_sts,
    output kst_pkg::t_kst_cmd o_cmd
);
    import kst_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       scan_done;

    assign scan_done = i_sts.hit | i_sts.exhausted;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Drive handshakes and datapath commands
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_cmd.load   = (r_state == S_IDLE) & i_in_valid;
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.finish = (r_state == S_SCAN) & scan_done;

endmodule

@@ rtl/kst_dp.sv @@
// Datapath: key store, scan pointer, compare and result registers.
`timescale 1ns / 1ps

module kst_dp #(
    parameter int CAPACITY = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kst_pkg::t_kst_in  i_req,
    input  kst_pkg::t_kst_cmd i_cmd,
    output kst_pkg::t_kst_sts o_sts,
    output kst_pkg::t_kst_out o_rsp
);
    import kst_pkg::*;

    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [KEY_W-1:0] mem [CAPACITY];

    logic [KEY_W-1:0]   r_key;
    logic               r_func;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_rd_idx;
    logic               r_cmp_vld;
    logic [PTR_W-1:0]   r_cmp_idx;
    logic [KEY_W-1:0]   r_rdata;
    logic               r_found;
    logic [CNT_W-1:0]   r_label;
    logic               r_full;

    logic               issue;
    logic               hit;
    logic               room;
    logic               append;
    logic [CNT_W-1:0]   hit_label;
    logic [CNT_W+LABEL_W-1:0] label_ext;
    logic [CNT_W+LABEL_W-1:0] count_ext;

    assign issue     = i_cmd.scan & (r_rd_idx < r_count);
    assign hit       = r_cmp_vld & (r_rdata == r_key);
    assign room      = (r_count < CNT_W'(CAPACITY));
    assign append    = i_cmd.finish & ~hit & (r_func == FUNC_INSERT) & room;
    assign hit_label = CNT_W'(r_cmp_idx) + CNT_W'(1);

    assign o_sts.hit       = hit;
    assign o_sts.exhausted = ~r_cmp_vld & ~(r_rd_idx < r_count);

    // Hold the request beat while it is worked on
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_req.key;
            r_func <= i_req.func;
        end
    end

    // Write a new key at the tail, read one stored key per scan cycle while unread keys remain
    always_ff @(posedge i_clk) begin
        if (append) begin
            mem[r_count[PTR_W-1:0]] <= r_key;
        end
        if (issue) begin
            r_rdata <= mem[r_rd_idx[PTR_W-1:0]];
        end
    end

    // Advance the scan pointer and track the read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.scan) begin
            r_cmp_vld <= issue & ~hit;
            if (issue) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_cmp_idx <= r_rd_idx[PTR_W-1:0];
        end
    end

    // Count stored keys
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (append) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Capture the result at the end of the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_found <= hit;
            r_full  <= ~hit & (r_func == FUNC_INSERT) & ~room;
            if (hit) begin
                r_label <= hit_label;
            end else if (append) begin
                r_label <= r_count + CNT_W'(1);
            end else begin
                r_label <= '0;
            end
        end
    end

    // Fit label and count to the 9-bit result fields
    assign label_ext = {{LABEL_W{1'b0}}, r_label};
    assign count_ext = {{LABEL_W{1'b0}}, r_count};

    assign o_rsp.found       = r_found;
    assign o_rsp.label       = label_ext[LABEL_W-1:0];
    assign o_rsp.entry_count = count_ext[LABEL_W-1:0];
    assign o_rsp.table_full  = r_full;

endmodule

@@ rtl/key_to_sequential_id_table_core.sv @@
// Top level of the key to sequential id table.
//
// Maps sparse 31-bit keys to dense labels 1, 2, 3 ... in order of first
// insertion. A request beat on i_in carries func (insert or lookup) and key;
// every request yields exactly one result beat on o_out with found, label,
// entry_count and table_full.
// Both channels use valid/ready; a beat moves when both are high.
// One request is handled at a time. The key store is scanned one entry per
// cycle through its registered read port. Each request is accepted, then
// scanned until a hit or until every stored key has been compared, then
// presented as a result until it is taken.
// A new key is appended at the end of the scan in the same cycle.
// If the receiver stalls, the result is held on o_out and i_in.ready stays
// low until the result beat is taken.
// Reset clears the stored-key count; the key store itself needs no clearing,
// since only entries below the count are ever read.
`timescale 1ns / 1ps

module key_to_sequential_id_table_core #(
    parameter int CAPACITY = 256
) (
    input logic i_clk,
    input logic i_rst_n,
    kst_in_if.sink    i_in,
    kst_out_if.source o_out
);
    import kst_pkg::*;

    t_kst_cmd cmd;
    t_kst_sts sts;

    // Sequence each request
    kst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Store, scan and build the result
    kst_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in.data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_out.data)
    );

endmodule

@@ tb/tb_key_to_sequential_id_table_core.sv @@
// Self-checking testbench for the key to sequential id table core.
`timescale 1ns / 1ps

module tb_key_to_sequential_id_table_core;

    import kst_pkg::*;

    localparam int CAPACITY   = 256;
    localparam int N_RANDOM   = 1790;
    localparam int QUIET_MAX  = 20 * (CAPACITY + 4);
    localparam int CALM_FROM  = 300;
    localparam int CALM_TO    = 520;
    localparam int DRAIN_AT   = 1100;

    logic clk;
    logic rst_n;

    kst_in_if  in_ch ();
    kst_out_if out_ch ();

    key_to_sequential_id_table_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predictor state: keys in arrival order and the number stored
    logic [KEY_W-1:0] key_table [CAPACITY];
    int               stored_n = 0;

    t_kst_in          request_q [$];
    t_kst_out         label_q   [$];
    logic [KEY_W-1:0] issued_keys [$];

    int n_errors    = 0;
    int sent_n      = 0;
    int accepted_n  = 0;
    int quiet_cycles = 0;

    // Map one request onto the predicted table and return its result beat
    function automatic t_kst_out map_key(t_kst_in req);
        t_kst_out r;
        int       slot;
        r    = '0;
        slot = -1;
        for (int s = 0; s < stored_n; s++) begin
            if (slot < 0 && key_table[s] == req.key)
                slot = s;
        end
        if (slot >= 0) begin
            r.found = 1'b1;
            r.label = LABEL_W'(slot + 1);
        end else if (req.func == FUNC_INSERT) begin
            if (stored_n < CAPACITY) begin
                key_table[stored_n] = req.key;
                stored_n++;
                r.label = LABEL_W'(stored_n);
            end else begin
                r.table_full = 1'b1;
            end
        end
        r.entry_count = LABEL_W'(stored_n);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        n_errors++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic queue_request(logic func, logic [KEY_W-1:0] key);
        t_kst_in req;
        req.func = func;
        req.key  = key;
        request_q.push_back(req);
        if (func == FUNC_INSERT)
            issued_keys.push_back(key);
    endtask

    function automatic logic idle_roll(int acc);
        return !(acc >= CALM_FROM && acc < CALM_TO) && $urandom_range(99) < 21;
    endfunction

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Request driver: present queued beats, predict each accepted one
    always @(posedge clk) begin
        logic go;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                label_q.push_back(map_key(in_ch.data));
                accepted_n++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                // hold off one beat until the table has answered everything
                go = request_q.size() != 0 && !idle_roll(accepted_n) &&
                     !(sent_n == DRAIN_AT && label_q.size() != 0);
                if (go) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= request_q.pop_front();
                    sent_n++;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random backpressure, compare with oldest prediction
    always @(posedge clk) begin
        t_kst_out want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (label_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = label_q.pop_front();
                    check_field("found", int'(out_ch.data.found), int'(want.found));
                    check_field("label", int'(out_ch.data.label), int'(want.label));
                    check_field("entry_count", int'(out_ch.data.entry_count),
                                int'(want.entry_count));
                    check_field("table_full", int'(out_ch.data.table_full),
                                int'(want.table_full));
                end
            end
            out_ch.ready <= !idle_roll(accepted_n);
        end
    end

    // Count cycles with no beat on either channel
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_MAX)
            @(posedge clk);
        $display("tb_key_to_sequential_id_table_core failed");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        logic             func;
        logic [KEY_W-1:0] key;
        int               pick;

        rst_n        = 1'b0;

        // Directed: key extremes, both functions, repeats and misses
        queue_request(FUNC_LOOKUP, 31'h0000_0000);   // miss on empty table
        queue_request(FUNC_INSERT, 31'h0000_0000);
        queue_request(FUNC_INSERT, 31'h7FFF_FFFF);
        queue_request(FUNC_INSERT, 31'h0000_0000);   // existing key keeps label
        queue_request(FUNC_LOOKUP, 31'h7FFF_FFFF);
        queue_request(FUNC_LOOKUP, 31'h7FFF_FFFE);   // near miss
        queue_request(FUNC_INSERT, 31'h4000_0000);
        queue_request(FUNC_LOOKUP, 31'h0000_0001);
        queue_request(FUNC_INSERT, 31'h0000_0001);
        queue_request(FUNC_INSERT, 31'h2AAA_AAAA);
        queue_request(FUNC_INSERT, 31'h5555_5555);
        queue_request(FUNC_LOOKUP, 31'h5555_5555);
        queue_request(FUNC_INSERT, 31'h7FFF_FFFF);
        queue_request(FUNC_LOOKUP, 31'h4000_0000);
        queue_request(FUNC_LOOKUP, 31'h2AAA_AAAB);

        // Random: fresh and known keys in equal share, plus known keys with one bit
        // flipped; enough fresh inserts to fill the table, then keep hitting it full
        repeat (N_RANDOM) begin
            func = ($urandom_range(99) < 60) ? FUNC_INSERT : FUNC_LOOKUP;
            pick = $urandom_range(99);
            if (pick < 45)
                key = KEY_W'($urandom);
            else if (pick < 90)
                key = issued_keys[$urandom_range(issued_keys.size() - 1)];
            else
                key = issued_keys[$urandom_range(issued_keys.size() - 1)] ^
                      (KEY_W'(1) << $urandom_range(KEY_W - 1));
            queue_request(func, key);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || in_ch.valid || label_q.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);

        if (n_errors == 0 && label_q.size() == 0)
            $display("tb_key_to_sequential_id_table_core passed");
        else
            $display("tb_key_to_sequential_id_table_core failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/kst_pkg.sv
rtl/kst_in_if.sv
rtl/kst_out_if.sv
rtl/kst_ctrl.sv
rtl/kst_dp.sv
rtl/key_to_sequential_id_table_core.sv
tb/tb_key_to_sequential_id_table_core.sv
